// ===== design/tsc_pkg.sv =====
// Shared types, constants and modular helpers for the three-rotor cipher.
package tsc_pkg;

  localparam int SymW        = 6;
  localparam int RotorCount  = 3;
  localparam int QueueDepth  = 4;
  localparam int QueuePtrW   = 2;
  localparam int QueueCntW   = 3;

  localparam logic [3:0] PosStepThree = 4'd4;
  localparam logic [3:0] PosStepTwo   = 4'd8;
  localparam logic [3:0] PosStepOne   = 4'd12;
  localparam logic [3:0] PosMax       = 4'd15;

  typedef enum logic [1:0] {
    OpLoad    = 2'd0,
    OpEncrypt = 2'd1,
    OpDecrypt = 2'd2,
    OpUnused  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CfgRotorOne   = 2'd0,
    CfgRotorTwo   = 2'd1,
    CfgRotorThree = 2'd2,
    CfgNone       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [SymW-1:0] symbol;
    logic [1:0]      table_select;
    logic [SymW-1:0] table_index;
    logic            end_of_message;
  } cipher_in_t;

  typedef struct packed {
    logic [SymW-1:0] out_symbol;
    logic            out_last;
  } cipher_out_t;

  typedef struct packed {
    op_e                             op;
    logic [SymW-1:0]                 sym;
    logic [1:0]                      sel;
    logic [SymW-1:0]                 idx;
    logic [RotorCount-1:0][SymW-1:0] off;
    logic                            last;
  } work_t;

  function automatic logic [SymW-1:0] sub_mod(input logic [SymW-1:0] a,
                                              input logic [SymW-1:0] b,
                                              input logic [SymW:0]   n);
    logic [SymW:0] d;
    if (a >= b) begin
      d = {1'b0, a} - {1'b0, b};
    end else begin
      d = {1'b0, a} + n - {1'b0, b};
    end
    return d[SymW-1:0];
  endfunction

  function automatic logic [SymW-1:0] add_mod(input logic [SymW-1:0] a,
                                              input logic [SymW-1:0] b,
                                              input logic [SymW:0]   n);
    logic [SymW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= n) begin
      s = s - n;
    end
    return s[SymW-1:0];
  endfunction

  function automatic logic [SymW-1:0] inc_mod(input logic [SymW-1:0] a,
                                              input logic [SymW:0]   n);
    logic [SymW:0] s;
    s = {1'b0, a} + 7'd1;
    if (s >= n) begin
      s = '0;
    end
    return s[SymW-1:0];
  endfunction

endpackage

// ===== design/tsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tsc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 37
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tsc_front.sv =====
// Front end: accepts words, holds key and rotor state, classifies and steps rotors.
module tsc_front #(
  parameter int SYMBOL_COUNT = 37
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  tsc_pkg::cipher_in_t      in_word_i,
  output logic                     in_stall_o,
  input  logic                     cfg_valid_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [tsc_pkg::SymW-1:0] cfg_data_i,
  input  logic                     q_full_i,
  output logic                     push_valid_o,
  output tsc_pkg::work_t           push_work_o
);

  localparam logic [tsc_pkg::SymW:0] N = (tsc_pkg::SymW+1)'(SYMBOL_COUNT);

  logic [tsc_pkg::SymW-1:0] mod_lut [64];
  logic [tsc_pkg::SymW-1:0] key_q [tsc_pkg::RotorCount];
  logic [tsc_pkg::RotorCount-1:0][tsc_pkg::SymW-1:0] off_q, off_step;
  logic [3:0]               pos_q;
  logic                     accept, is_xform, load_ok;
  tsc_pkg::op_e             op;

  for (genvar g = 0; g < 64; g++) begin : g_lut
    assign mod_lut[g] = tsc_pkg::SymW'(g % SYMBOL_COUNT);
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign op         = tsc_pkg::op_e'(in_word_i.opcode);
  assign is_xform   = (op == tsc_pkg::OpEncrypt) || (op == tsc_pkg::OpDecrypt);
  assign load_ok    = (op == tsc_pkg::OpLoad)
                   && ({30'd0, in_word_i.table_select} < tsc_pkg::RotorCount)
                   && ({1'b0, in_word_i.table_index} < N)
                   && ({1'b0, in_word_i.symbol} < N);

  always_comb begin
    off_step    = off_q;
    if (pos_q > tsc_pkg::PosStepThree) off_step[2] = tsc_pkg::inc_mod(off_q[2], N);
    if (pos_q > tsc_pkg::PosStepTwo)   off_step[1] = tsc_pkg::inc_mod(off_q[1], N);
    if (pos_q > tsc_pkg::PosStepOne)   off_step[0] = tsc_pkg::inc_mod(off_q[0], N);
  end

  always_comb begin
    push_work_o.op   = op;
    push_work_o.sym  = is_xform ? mod_lut[in_word_i.symbol] : in_word_i.symbol;
    push_work_o.sel  = in_word_i.table_select;
    push_work_o.idx  = in_word_i.table_index;
    push_work_o.off  = off_step;
    push_work_o.last = in_word_i.end_of_message;
  end

  assign push_valid_o = accept && (is_xform || load_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < tsc_pkg::RotorCount; r++) begin
        key_q[r] <= '0;
      end
      off_q <= '0;
      pos_q <= '0;
    end else begin
      priority if (cfg_valid_i) begin
        unique case (tsc_pkg::cfg_reg_e'(cfg_index_i))
          tsc_pkg::CfgRotorOne: begin
            key_q[0] <= mod_lut[cfg_data_i];
            off_q[0] <= mod_lut[cfg_data_i];
          end
          tsc_pkg::CfgRotorTwo: begin
            key_q[1] <= mod_lut[cfg_data_i];
            off_q[1] <= mod_lut[cfg_data_i];
          end
          tsc_pkg::CfgRotorThree: begin
            key_q[2] <= mod_lut[cfg_data_i];
            off_q[2] <= mod_lut[cfg_data_i];
          end
          default: ;
        endcase
      end else if (accept && is_xform) begin
        if (in_word_i.end_of_message) begin
          for (int r = 0; r < tsc_pkg::RotorCount; r++) begin
            off_q[r] <= key_q[r];
          end
          pos_q <= '0;
        end else begin
          off_q <= off_step;
          if (pos_q != tsc_pkg::PosMax) pos_q <= pos_q + 4'd1;
        end
      end
    end
  end

endmodule

// ===== design/tsc_queue.sv =====
// Short FIFO of decoded work words between front and back.
module tsc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tsc_pkg::work_t push_work_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output tsc_pkg::work_t head_o
);

  tsc_pkg::work_t                  buf_q [tsc_pkg::QueueDepth];
  logic [tsc_pkg::QueuePtrW-1:0]   wr_q, rd_q;
  logic [tsc_pkg::QueueCntW-1:0]   cnt_q;
  logic                            do_push, do_pop;

  assign full_o       = (cnt_q == tsc_pkg::QueueCntW'(tsc_pkg::QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = buf_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= push_work_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + tsc_pkg::QueuePtrW'(1);
      if (do_pop)  rd_q <= rd_q + tsc_pkg::QueuePtrW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + tsc_pkg::QueueCntW'(1);
        2'b01:   cnt_q <= cnt_q - tsc_pkg::QueueCntW'(1);
        default: ;
      endcase
    end
  end

endmodule

// ===== design/tsc_back.sv =====
// Back end: three table-lookup stages over the rotor RAMs and the result register.
module tsc_back #(
  parameter int SYMBOL_COUNT = 37
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  tsc_pkg::work_t       head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  output tsc_pkg::cipher_out_t out_word_o,
  input  logic                 out_stall_i
);

  localparam int              AW = $clog2(SYMBOL_COUNT);
  localparam int              NS = tsc_pkg::RotorCount;
  localparam logic [tsc_pkg::SymW:0] N = (tsc_pkg::SymW+1)'(SYMBOL_COUNT);

  tsc_pkg::work_t           item [NS+1];
  logic [NS:0]              vld;
  logic [tsc_pkg::SymW-1:0] val  [NS+1];
  logic [tsc_pkg::SymW-1:0] addr [NS];
  logic [tsc_pkg::SymW-1:0] fwd_rd [NS];
  logic [tsc_pkg::SymW-1:0] inv_rd [NS];
  tsc_pkg::work_t           stg_q [NS];
  logic [NS-1:0]            stg_valid_q;
  logic                     out_valid_q;
  tsc_pkg::cipher_out_t     out_q;
  logic                     adv;

  assign adv     = !out_valid_q || !out_stall_i;
  assign pop_o   = adv && head_valid_i;
  assign item[0] = head_i;
  assign vld[0]  = head_valid_i;
  assign val[0]  = head_i.sym;

  for (genvar s = 1; s <= NS; s++) begin : g_link
    assign item[s] = stg_q[s-1];
    assign vld[s]  = stg_valid_q[s-1];
    assign val[s]  = (item[s].op == tsc_pkg::OpEncrypt) ? fwd_rd[s-1]
                   : tsc_pkg::add_mod(inv_rd[s-1], item[s].off[NS-s], N);
  end

  // Stage s reads forward table s and inverse table NS-1-s; loads write there too.
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic is_load;

    assign is_load = vld[s] && (item[s].op == tsc_pkg::OpLoad);
    assign addr[s] = (item[s].op == tsc_pkg::OpEncrypt)
                   ? tsc_pkg::sub_mod(val[s], item[s].off[s], N) : val[s];

    tsc_ram #(.WIDTH(tsc_pkg::SymW), .DEPTH(SYMBOL_COUNT)) u_fwd (
      .clk_i   (clk_i),
      .we_i    (adv && is_load && (item[s].sel == 2'(s))),
      .waddr_i (item[s].idx[AW-1:0]),
      .wdata_i (item[s].sym),
      .re_i    (adv),
      .raddr_i (addr[s][AW-1:0]),
      .rdata_o (fwd_rd[s])
    );

    tsc_ram #(.WIDTH(tsc_pkg::SymW), .DEPTH(SYMBOL_COUNT)) u_inv (
      .clk_i   (clk_i),
      .we_i    (adv && is_load && (item[s].sel == 2'(NS-1-s))),
      .waddr_i (item[s].sym[AW-1:0]),
      .wdata_i (item[s].idx),
      .re_i    (adv),
      .raddr_i (addr[s][AW-1:0]),
      .rdata_o (inv_rd[s])
    );

    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[s] <= item[s];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_valid_q[s] <= 1'b0;
      end else if (adv) begin
        stg_valid_q[s] <= vld[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld[NS] && (item[NS].op != tsc_pkg::OpLoad);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_symbol <= val[NS];
      out_q.out_last   <= item[NS].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== design/three_rotor_substitution_cipher_core.sv =====
// Top level of the three-rotor substitution cipher.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------
//  in       | in_valid_i / in_stall_o  | in_word_i   (cipher_in_t)
//  out      | out_valid_o / out_stall_i| out_word_o  (cipher_out_t)
//  cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One word per cycle without output stalls; a symbol enters the queue at its accepting
// edge and reaches out_valid_o through three registered rotor-RAM reads, result register.
// Reset clears rotor state, key, queue and pipeline; tables hold garbage until loaded.
// An output stall freezes the back pipeline; the 4-word queue then fills and
// raises in_stall_o. cfg_ready_o is always high.
module three_rotor_substitution_cipher_core #(
  parameter int SYMBOL_COUNT = 37
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  tsc_pkg::cipher_in_t      in_word_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output tsc_pkg::cipher_out_t     out_word_o,
  input  logic                     out_stall_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [tsc_pkg::SymW-1:0] cfg_data_i
);

  logic           push_valid, q_full, pop, head_valid;
  tsc_pkg::work_t push_work, head;

  assign cfg_ready_o = 1'b1;

  tsc_front #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_word_i    (in_word_i),
    .in_stall_o   (in_stall_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .push_valid_o (push_valid),
    .push_work_o  (push_work)
  );

  tsc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_work_i  (push_work),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  tsc_back #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

// ===== design/tsc_checker.sv =====
// Port-level checker for the cipher core, bound to the top level.
module tsc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input tsc_pkg::cipher_out_t out_word_o,
  input logic                 out_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // the queue can only be full after the back end was held by an output stall
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty after reset");

endmodule

bind three_rotor_substitution_cipher_core tsc_checker u_tsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_word_o  (out_word_o),
  .out_stall_i (out_stall_i)
);

// ===== test/three_rotor_substitution_cipher_core_test.sv =====
// Self-checking testbench for the three-rotor substitution cipher core.
`timescale 1ns / 100ps

module three_rotor_substitution_cipher_core_test;

  localparam int SymbolCount = 37;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 12;
  localparam int HoldCycles  = 80;
  localparam int PhaseCount  = 8;
  localparam int PhaseWords  = 32;

  typedef struct {
    tsc_pkg::cipher_in_t  word;
    bit                   typed;
    tsc_pkg::cipher_out_t want;
  } vector_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  tsc_pkg::cipher_in_t      in_word_i = '0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  tsc_pkg::cipher_out_t     out_word_o;
  logic                     out_stall_i = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [1:0]               cfg_index_i = '0;
  logic [tsc_pkg::SymW-1:0] cfg_data_i = '0;

  three_rotor_substitution_cipher_core #(.SYMBOL_COUNT(SymbolCount)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_word_i, .in_stall_o,
    .out_valid_o, .out_word_o, .out_stall_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // cipher state mirror
  logic [tsc_pkg::SymW-1:0] fwd_perm [tsc_pkg::RotorCount][SymbolCount];
  logic [tsc_pkg::SymW-1:0] inv_perm [tsc_pkg::RotorCount][SymbolCount];
  int              key_start [tsc_pkg::RotorCount];
  int              live_offset [tsc_pkg::RotorCount];
  int              msg_pos;

  tsc_pkg::cipher_out_t pending_results [$];
  vector_t         directed_rows [$];
  tsc_pkg::cipher_out_t want;
  int              mismatch_count = 0;
  int              words_sent = 0;
  int              results_checked = 0;
  int              key_settings = 0;
  bit              burst = 1'b0;
  bit              no_idle = 1'b0;
  bit              hold_off_req = 1'b0;

  function automatic void queue_result(input tsc_pkg::cipher_out_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic void queue_row(input vector_t t);
    directed_rows = {directed_rows, t};
  endfunction

  function automatic void restore_key();
    for (int r = 0; r < tsc_pkg::RotorCount; r++) live_offset[r] = key_start[r] % SymbolCount;
  endfunction

  function automatic bit cipher_step(input tsc_pkg::cipher_in_t w,
                                     output tsc_pkg::cipher_out_t res);
    int v;
    res = '0;
    if (tsc_pkg::op_e'(w.opcode) == tsc_pkg::OpLoad) begin
      if (w.table_select < tsc_pkg::RotorCount && w.table_index < SymbolCount &&
          w.symbol < SymbolCount) begin
        fwd_perm[w.table_select][w.table_index] = w.symbol;
        inv_perm[w.table_select][w.symbol] = w.table_index;
      end
      return 1'b0;
    end
    if (tsc_pkg::op_e'(w.opcode) == tsc_pkg::OpUnused) return 1'b0;
    if (msg_pos > tsc_pkg::PosStepThree)
      live_offset[tsc_pkg::CfgRotorThree] =
        (live_offset[tsc_pkg::CfgRotorThree] + 1) % SymbolCount;
    if (msg_pos > tsc_pkg::PosStepTwo)
      live_offset[tsc_pkg::CfgRotorTwo] = (live_offset[tsc_pkg::CfgRotorTwo] + 1) % SymbolCount;
    if (msg_pos > tsc_pkg::PosStepOne)
      live_offset[tsc_pkg::CfgRotorOne] = (live_offset[tsc_pkg::CfgRotorOne] + 1) % SymbolCount;
    v = w.symbol % SymbolCount;
    if (tsc_pkg::op_e'(w.opcode) == tsc_pkg::OpEncrypt) begin
      for (int r = 0; r < tsc_pkg::RotorCount; r++) begin
        v = (v + SymbolCount - live_offset[r]) % SymbolCount;
        v = fwd_perm[r][v] % SymbolCount;
      end
    end else begin
      for (int r = tsc_pkg::RotorCount - 1; r >= 0; r--) begin
        v = inv_perm[r][v] % SymbolCount;
        v = (v + live_offset[r]) % SymbolCount;
      end
    end
    res.out_symbol = v[tsc_pkg::SymW-1:0];
    res.out_last   = w.end_of_message;
    if (msg_pos < tsc_pkg::PosMax) msg_pos++;
    if (w.end_of_message) begin
      restore_key();
      msg_pos = 0;
    end
    return 1'b1;
  endfunction

  function automatic tsc_pkg::cipher_in_t make_word(tsc_pkg::op_e op, int sym, int sel,
                                                    int idx, bit last);
    tsc_pkg::cipher_in_t w;
    w.opcode         = op;
    w.symbol         = sym[tsc_pkg::SymW-1:0];
    w.table_select   = sel[1:0];
    w.table_index    = idx[tsc_pkg::SymW-1:0];
    w.end_of_message = last;
    return w;
  endfunction

  function automatic vector_t row(tsc_pkg::op_e op, int sym, int sel, int idx, bit last,
                                  bit typed, int osym, bit olast);
    vector_t t;
    t.word            = make_word(op, sym, sel, idx, last);
    t.typed           = typed;
    t.want.out_symbol = osym[tsc_pkg::SymW-1:0];
    t.want.out_last   = olast;
    return t;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_word(input tsc_pkg::cipher_in_t w, input bit typed,
                           input tsc_pkg::cipher_out_t typed_res);
    tsc_pkg::cipher_out_t res;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    if (cipher_step(w, res)) queue_result(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  task automatic send_plain(input tsc_pkg::cipher_in_t w);
    send_word(w, 1'b0, '0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_key(input tsc_pkg::cfg_reg_e idx, input int data);
    cfg_index_i <= idx;
    cfg_data_i  <= data[tsc_pkg::SymW-1:0];
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx != tsc_pkg::CfgNone) begin
      key_start[idx]   = data & 6'h3f;
      live_offset[idx] = key_start[idx] % SymbolCount;
    end
    @(negedge clk_i);
  endtask

  task automatic load_permutation(input int sel);
    int perm [SymbolCount];
    int j, t;
    for (int i = 0; i < SymbolCount; i++) perm[i] = i;
    for (int i = SymbolCount - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < SymbolCount; i++)
      send_plain(make_word(tsc_pkg::OpLoad, perm[i], sel, i, $urandom_range(0, 1)));
  endtask

  task automatic send_message(input int len, input bit close);
    int sym;
    for (int k = 0; k < len; k++) begin
      sym = ($urandom_range(0, 9) == 0) ? $urandom_range(37, 63) : $urandom_range(0, 36);
      send_plain(make_word($urandom_range(0, 1) ? tsc_pkg::OpEncrypt : tsc_pkg::OpDecrypt,
                           sym, $urandom_range(0, 3), $urandom_range(0, 63),
                           close && (k == len - 1)));
    end
  endtask

  // returns 1 when the word changes state
  task automatic send_noise(output bit counted);
    int kind;
    kind = $urandom_range(0, 3);
    counted = 1'b0;
    case (kind)
      0: send_plain(make_word(tsc_pkg::OpUnused, $urandom_range(0, 63), $urandom_range(0, 3),
                              $urandom_range(0, 63), $urandom_range(0, 1)));
      1: begin
        case ($urandom_range(0, 2))
          0: send_plain(make_word(tsc_pkg::OpLoad, $urandom_range(0, 36), 3,
                                  $urandom_range(0, 36), $urandom_range(0, 1)));
          1: send_plain(make_word(tsc_pkg::OpLoad, $urandom_range(0, 36),
                                  $urandom_range(0, 2), $urandom_range(37, 63),
                                  $urandom_range(0, 1)));
          default: send_plain(make_word(tsc_pkg::OpLoad, $urandom_range(37, 63),
                                        $urandom_range(0, 2), $urandom_range(0, 36),
                                        $urandom_range(0, 1)));
        endcase
      end
      default: begin
        send_plain(make_word(tsc_pkg::OpLoad, $urandom_range(0, 36), $urandom_range(0, 2),
                             $urandom_range(0, 36), $urandom_range(0, 1)));
        counted = 1'b1;
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, got symbol %0d last %0b",
                 $time, out_word_o.out_symbol, out_word_o.out_last);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_word_o.out_symbol !== want.out_symbol) begin
          $display("%0t: out_symbol expected %0d got %0d",
                   $time, want.out_symbol, out_word_o.out_symbol);
          mismatch_count++;
        end
        if (out_word_o.out_last !== want.out_last) begin
          $display("%0t: out_last expected %0b got %0b",
                   $time, want.out_last, out_word_o.out_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : receiver
    int stall_left, free_left;
    stall_left = 0;
    free_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HoldCycles;
        free_left    = 0;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        out_stall_i <= 1'b0;
        free_left--;
      end else begin
        out_stall_i <= 1'b0;
        free_left  = $urandom_range(0, 8);
        stall_left = no_idle ? 0 : pick_stall();
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("three_rotor_substitution_cipher_core_test failed");
    $finish;
  end

  initial begin : stimulus
    int budget, len;
    bit counted;
    for (int r = 0; r < tsc_pkg::RotorCount; r++) key_start[r] = 0;
    restore_key();
    msg_pos = 0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // identity tables so the early rows can be read off directly
    for (int s = 0; s < tsc_pkg::RotorCount; s++)
      for (int i = 0; i < SymbolCount; i++)
        send_plain(make_word(tsc_pkg::OpLoad, i, s, i, 1'b0));

    queue_row(row(tsc_pkg::OpEncrypt,  0, 0,  0, 0, 1,  0, 0));
    queue_row(row(tsc_pkg::OpEncrypt, 36, 3, 63, 0, 1, 36, 0));
    queue_row(row(tsc_pkg::OpDecrypt, 36, 0,  0, 0, 1, 36, 0));
    queue_row(row(tsc_pkg::OpEncrypt, 63, 0,  0, 0, 1, 26, 0));
    queue_row(row(tsc_pkg::OpDecrypt, 37, 0,  0, 0, 1,  0, 0));
    queue_row(row(tsc_pkg::OpUnused,  63, 3, 63, 1, 0,  0, 0));
    queue_row(row(tsc_pkg::OpLoad,     0, 3,  0, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpLoad,     5, 0, 63, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpLoad,    63, 0,  5, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpLoad,    36, 1, 36, 1, 0,  0, 0));
    // rotor three starts stepping
    queue_row(row(tsc_pkg::OpEncrypt, 10, 0,  0, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpDecrypt, 10, 0,  0, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpEncrypt,  1, 0,  0, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpDecrypt,  2, 0,  0, 0, 0,  0, 0));
    // rotor two joins
    queue_row(row(tsc_pkg::OpEncrypt,  0, 0,  0, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpDecrypt, 36, 0,  0, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpEncrypt, 20, 0,  0, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpEncrypt, 33, 0,  0, 0, 0,  0, 0));
    // all three step, position saturates
    queue_row(row(tsc_pkg::OpEncrypt,  0, 0,  0, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpDecrypt,  0, 0,  0, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpEncrypt, 36, 0,  0, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpEncrypt, 36, 0,  0, 0, 0,  0, 0));
    queue_row(row(tsc_pkg::OpDecrypt, 36, 0,  0, 1, 0,  0, 0));
    queue_row(row(tsc_pkg::OpEncrypt,  7, 0,  0, 0, 1,  7, 0));
    queue_row(row(tsc_pkg::OpEncrypt,  7, 0,  0, 1, 1,  7, 1));
    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    settle();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          write_key(tsc_pkg::CfgRotorOne, 36);
          write_key(tsc_pkg::CfgRotorTwo, 36);
          write_key(tsc_pkg::CfgRotorThree, 36);
        end
        1: begin
          write_key(tsc_pkg::CfgRotorThree, 63);
          write_key(tsc_pkg::CfgRotorTwo, 63);
          write_key(tsc_pkg::CfgRotorOne, 63);
          write_key(tsc_pkg::CfgNone, $urandom_range(0, 63));
        end
        2: begin
          write_key(tsc_pkg::CfgRotorOne, 0);
          write_key(tsc_pkg::CfgRotorTwo, 0);
          write_key(tsc_pkg::CfgRotorThree, 0);
        end
        4: begin
          write_key(tsc_pkg::CfgRotorOne, 37);
          write_key(tsc_pkg::CfgRotorTwo, 1);
          write_key(tsc_pkg::CfgRotorThree, 35);
        end
        default: begin
          write_key(tsc_pkg::CfgRotorOne, $urandom_range(0, 63));
          write_key(tsc_pkg::CfgRotorTwo, $urandom_range(0, 63));
          write_key(tsc_pkg::CfgRotorThree, $urandom_range(0, 63));
        end
      endcase
      cfg_valid_i <= 1'b0;
      key_settings++;

      burst   = (phase == 3) || (phase == 5);
      no_idle = (phase == 3);
      if (phase == 5) hold_off_req = 1'b1;

      if (phase % 3 == 0) load_permutation($urandom_range(0, 2));

      budget = PhaseWords;
      while (budget > 0) begin
        if ($urandom_range(0, 3) == 0) begin
          send_noise(counted);
          if (counted) budget--;
        end else begin
          len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 20);
          send_message(len, $urandom_range(0, 7) != 0);
          budget -= len;
        end
      end
      settle();
    end
    burst   = 1'b0;
    no_idle = 1'b0;

    $display("%0d words sent, %0d results checked over %0d key settings", words_sent,
             results_checked, key_settings);
    $display("covered table loads, stepping up to saturation, message resets and noise");
    if (pending_results.size() != 0)
      $display("%0t: expected %0d more results, got none", $time, pending_results.size());
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("three_rotor_substitution_cipher_core_test passed");
    else
      $display("three_rotor_substitution_cipher_core_test failed");
    $finish;
  end

endmodule
